// ===== rtl/lese_pkg.sv =====
// lese_pkg: shared constants, command codes and the sine table builder
// for the led strip effect engine; no dependencies
package lese_pkg;

  localparam int FAN_NUM_DEF      = 3;
  localparam int LEDS_PER_FAN_DEF = 8;
  localparam int LED_NUM_DEF      = 24;

  localparam int ROM_LEN    = 668;
  localparam int ROM_AW     = 10;
  localparam int PHASE_WRAP = 628;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_SET  = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  localparam logic [1:0] MODE_STATIC = 2'd0;
  localparam logic [1:0] MODE_RAIN   = 2'd1;
  localparam logic [1:0] MODE_BREATH = 2'd2;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_SPEED = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;

  localparam logic [63:0] Q_PI      = 64'hC90FDAA2;
  localparam logic [63:0] Q_HALF_PI = 64'h6487ED51;
  localparam logic [63:0] Q_TWO_PI  = 64'h1921FB544;

  typedef logic [7:0] sine_rom_t [ROM_LEN];

  // shift and subtract divide, quotient above remainder
  function automatic logic [127:0] udiv64(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return {q, r};
  endfunction

  // fixed point taylor series, evaluated at elaboration only
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] a;
    logic [63:0] d;
    logic [127:0] qr;
    logic        neg;
    for (int i = 0; i < ROM_LEN; i++) begin
      qr = udiv64(64'(i) << 30, 64'd10);
      x = qr[127:64];
      qr = udiv64(x, Q_TWO_PI);
      x = qr[63:0];
      neg = 1'b0;
      if (x > Q_PI) begin
        neg = 1'b1;
        x = x - Q_PI;
      end
      if (x > Q_HALF_PI) x = Q_PI - x;
      x2 = (x * x) >> 30;
      t = x;
      s = x;
      for (int k = 1; k <= 12; k++) begin
        d = 64'((2 * k) * (2 * k + 1));
        qr = udiv64((t * x2) >> 30, d);
        t = qr[127:64];
        if ((k & 1) != 0) s = s - t;
        else s = s + t;
      end
      a = 64'd127 * s;
      if (!neg) rom[i] = 8'(64'd128 + (a >> 30));
      else rom[i] = 8'(64'd128 - ((a + 64'h3FFFFFFF) >> 30));
    end
    return rom;
  endfunction

endpackage

// ===== rtl/lese_sine_rom.sv =====
// lese_sine_rom: sine lookup table with registered read data
// depends on lese_pkg for the table builder
module lese_sine_rom (
  input  logic                       clk,
  input  logic [lese_pkg::ROM_AW-1:0] rd_addr,
  output logic [7:0]                 rd_data
);
  import lese_pkg::*;

  localparam sine_rom_t ROM = build_sine_rom();

  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (32'(rd_addr) < ROM_LEN) rd_data_r <= ROM[rd_addr];
    else rd_data_r <= '0;
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/led_strip_effect_engine.sv =====
// Effect engine for a chain of addressable LEDs. Each accepted request (a millisecond tick,
// a fan color write or an all-off command) that produces a frame gives LED_NUM results in
// strip order, GRB plus frame_last on the final LED. Per-LED colors live in a one-port
// store with registered reads; a frame sweep steps each LED through ST_A and ST_D (ST_A,
// ST_B, ST_C, ST_D in rainbow mode, for three reads of the single-port sine table), waiting
// in ST_D on an output stall. A breathing base change or an effect_mode write adds a table
// reload during which no request is taken. Depends on lese_pkg and lese_sine_rom.
module led_strip_effect_engine #(
  parameter int FAN_NUM      = lese_pkg::FAN_NUM_DEF,
  parameter int LEDS_PER_FAN = lese_pkg::LEDS_PER_FAN_DEF,
  parameter int LED_NUM      = lese_pkg::LED_NUM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_fan_id,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_led_index,
  output logic [7:0] out_green_out,
  output logic [7:0] out_red_out,
  output logic [7:0] out_blue_out,
  output logic       out_frame_last
);
  import lese_pkg::*;

  localparam int AW = (LED_NUM > 1) ? $clog2(LED_NUM) : 1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_A, ST_B, ST_C, ST_D, RL_MUL, RL_R, RL_G, RL_B, RL_END
  } state_t;

  typedef enum logic [1:0] {OP_SET, OP_OFF, OP_RAIN, OP_BREATH} op_t;

  state_t      state_r;
  op_t         op_r;
  logic [1:0]  mode_r;
  logic [7:0]  speed_r;
  logic [7:0]  step_r;
  logic [6:0]  wait_r;
  logic [7:0]  rframe_r;
  logic [7:0]  bpos_r;
  logic [7:0]  blevel_r;
  logic        falling_r;
  logic [23:0] base_r;
  logic        reload_r;
  logic [7:0]  reload_pos_r;
  logic [7:0]  reload_st_r;
  logic [5:0]  k_r;
  logic [9:0]  acc_r;
  logic [3:0]  rstep_r;
  logic [7:0]  fan_lo_r;
  logic [7:0]  fan_hi_r;
  logic [23:0] set_c_r;
  logic [23:0] frame_c_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [23:0] store_q_r;
  logic        store_vq_r;
  logic        out_valid_r;
  logic [5:0]  out_idx_r;
  logic [23:0] out_c_r;
  logic        out_last_r;

  logic [23:0] store_mem [LED_NUM];
  logic        vld_r [LED_NUM];

  logic [ROM_AW-1:0] rom_addr;
  logic [ROM_AW-1:0] pw;
  logic [7:0]        rom_q;

  lese_sine_rom u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  always_comb begin
    pw = (acc_r >= 10'(PHASE_WRAP)) ? '0 : acc_r;
    case (state_r)
      ST_A, RL_R: rom_addr = pw;
      ST_B, RL_G: rom_addr = pw + 10'd20;
      default:    rom_addr = pw + 10'd40;
    endcase
  end

  // frame period from clamped speed, divide by 11 via reciprocal
  logic [6:0]  spd_c;
  logic [9:0]  spd_y;
  logic [21:0] spd_p;
  logic [6:0]  period;
  logic [6:0]  wait_inc;
  always_comb begin
    if (speed_r == 8'd0) spd_c = 7'd1;
    else if (speed_r > 8'd100) spd_c = 7'd100;
    else spd_c = speed_r[6:0];
    spd_y  = 10'(spd_c - 7'd1) * 10'd10;
    spd_p  = 22'(spd_y) * 22'd2979;
    period = 7'd100 - spd_p[21:15];
    wait_inc = wait_r + 7'd1;
  end

  logic [7:0]  bst;
  logic [3:0]  rst;
  logic [8:0]  lvl_sum;
  logic [8:0]  pos_sum;
  logic [7:0]  pos_new;
  logic [15:0] g_mul;
  logic [15:0] r_mul;
  logic [15:0] b_mul;
  logic [15:0] fan_lo_w;
  logic [15:0] rl_prod;
  always_comb begin
    bst = (step_r == 8'd0) ? 8'd1 : step_r;
    rst = (step_r == 8'd0 || step_r > 8'd10) ? 4'd1 : step_r[3:0];
    lvl_sum = {1'b0, blevel_r} + {1'b0, bst};
    pos_sum = {1'b0, bpos_r} + {1'b0, bst};
    pos_new = pos_sum[8] ? 8'd0 : pos_sum[7:0];
    g_mul = base_r[23:16] * blevel_r;
    r_mul = base_r[15:8] * blevel_r;
    b_mul = base_r[7:0] * blevel_r;
    fan_lo_w = 16'(in_fan_id - 8'd1) * 16'(LEDS_PER_FAN);
    rl_prod = reload_pos_r * reload_st_r;
  end

  logic        out_free;
  logic        in_take;
  logic        k_in_fan;
  logic [23:0] store_rd;
  logic [23:0] new_c;
  logic        k_last;
  always_comb begin
    out_free = !out_valid_r || !out_stall;
    in_take  = in_valid && !in_stall;
    k_in_fan = ({2'b00, k_r} >= fan_lo_r) && ({2'b00, k_r} < fan_hi_r);
    store_rd = store_vq_r ? store_q_r : '0;
    k_last   = (k_r == 6'(LED_NUM - 1));
    case (op_r)
      OP_SET:    new_c = k_in_fan ? set_c_r : store_rd;
      OP_OFF:    new_c = '0;
      OP_RAIN:   new_c = {green_r, red_r, rom_q};
      OP_BREATH: new_c = frame_c_r;
      default:   new_c = '0;
    endcase
  end

  assign in_stall = !(state_r == ST_IDLE && !reload_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_A) store_q_r <= store_mem[k_r[AW-1:0]];
    if (state_r == ST_D && out_free) store_mem[k_r[AW-1:0]] <= new_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LED_NUM; i++) vld_r[i] <= 1'b0;
    end else if (state_r == ST_D && out_free) begin
      vld_r[k_r[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= OP_OFF;
      mode_r       <= MODE_STATIC;
      speed_r      <= 8'd50;
      step_r       <= 8'd1;
      wait_r       <= '0;
      rframe_r     <= '0;
      bpos_r       <= '0;
      blevel_r     <= '0;
      falling_r    <= 1'b0;
      base_r       <= '0;
      reload_r     <= 1'b0;
      reload_pos_r <= '0;
      reload_st_r  <= '0;
      out_valid_r  <= 1'b0;
      k_r          <= '0;
      acc_r        <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (reload_r) begin
            state_r <= RL_MUL;
          end else if (in_take) begin
            k_r <= '0;
            case (in_cmd)
              CMD_TICK: begin
                if (mode_r == MODE_RAIN || mode_r == MODE_BREATH) begin
                  wait_r <= (wait_inc >= period) ? 7'd0 : wait_inc;
                  if (wait_r == 7'd0) begin
                    state_r <= ST_A;
                    if (mode_r == MODE_RAIN) begin
                      op_r     <= OP_RAIN;
                      acc_r    <= {2'b00, rframe_r};
                      rstep_r  <= rst;
                      rframe_r <= rframe_r + 8'd1;
                    end else begin
                      op_r      <= OP_BREATH;
                      frame_c_r <= {g_mul[15:8], r_mul[15:8], b_mul[15:8]};
                      if ((!falling_r && lvl_sum[8] && bst == 8'd255)
                          || (falling_r && blevel_r < bst)) begin
                        bpos_r       <= pos_new;
                        blevel_r     <= '0;
                        falling_r    <= 1'b0;
                        reload_r     <= 1'b1;
                        reload_pos_r <= pos_new;
                        reload_st_r  <= bst;
                      end else if (!falling_r && lvl_sum[8]) begin
                        falling_r <= 1'b1;
                        blevel_r  <= 8'd254 - bst;
                      end else if (!falling_r) begin
                        blevel_r <= lvl_sum[7:0];
                      end else begin
                        blevel_r <= blevel_r - bst;
                      end
                    end
                  end
                end
              end
              CMD_SET: begin
                if (in_fan_id >= 8'd1 && in_fan_id <= 8'(FAN_NUM)) begin
                  op_r     <= OP_SET;
                  state_r  <= ST_A;
                  fan_lo_r <= fan_lo_w[7:0];
                  fan_hi_r <= fan_lo_w[7:0] + 8'(LEDS_PER_FAN);
                  set_c_r  <= {in_green_in, in_red_in, in_blue_in};
                end
              end
              CMD_OFF: begin
                op_r    <= OP_OFF;
                state_r <= ST_A;
              end
              default: ;
            endcase
          end
        end
        ST_A: begin
          store_vq_r <= vld_r[k_r[AW-1:0]];
          state_r    <= (op_r == OP_RAIN) ? ST_B : ST_D;
        end
        ST_B: begin
          red_r   <= rom_q;
          state_r <= ST_C;
        end
        ST_C: begin
          green_r <= rom_q;
          state_r <= ST_D;
        end
        ST_D: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= k_r;
            out_c_r     <= new_c;
            out_last_r  <= k_last;
            if (k_last) begin
              state_r <= ST_IDLE;
            end else begin
              k_r     <= k_r + 6'd1;
              acc_r   <= acc_r + 10'(rstep_r);
              state_r <= ST_A;
            end
          end
        end
        RL_MUL: begin
          acc_r   <= (rl_prod >= 16'(PHASE_WRAP)) ? 10'd0 : rl_prod[9:0];
          state_r <= RL_R;
        end
        RL_R: state_r <= RL_G;
        RL_G: begin
          red_r   <= rom_q;
          state_r <= RL_B;
        end
        RL_B: begin
          green_r <= rom_q;
          state_r <= RL_END;
        end
        RL_END: begin
          base_r   <= {green_r, red_r, rom_q};
          reload_r <= 1'b0;
          state_r  <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
      if (cfg_we) begin
        case (cfg_addr)
          REG_MODE: begin
            mode_r       <= cfg_wdata[1:0];
            wait_r       <= '0;
            rframe_r     <= '0;
            bpos_r       <= '0;
            blevel_r     <= '0;
            falling_r    <= 1'b0;
            reload_r     <= 1'b1;
            reload_pos_r <= '0;
          end
          REG_SPEED: speed_r <= cfg_wdata;
          REG_STEP:  step_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_index  = out_idx_r;
  assign out_green_out  = out_c_r[23:16];
  assign out_red_out    = out_c_r[15:8];
  assign out_blue_out   = out_c_r[7:0];
  assign out_frame_last = out_last_r;

endmodule

// ===== test/tb_led_strip_effect_engine.sv =====
// Self-checking testbench for led_strip_effect_engine: a directed table, then random requests,
// mostly with random input gaps and output stalls, each frame checked against a local predictor.
// Depends on lese_pkg and the engine RTL.
`timescale 1ns / 100ps

module tb_led_strip_effect_engine;
  import lese_pkg::*;

  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] CMD_SPARE  = 2'd3;
  localparam int LEDS       = LED_NUM_DEF;
  localparam int WDOG_LIMIT = 4000;
  localparam int SETTLE     = 40;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_addr;
  logic [7:0] cfg_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_cmd;
  logic [7:0] in_fan_id;
  logic [7:0] in_red_in;
  logic [7:0] in_green_in;
  logic [7:0] in_blue_in;
  logic       out_valid;
  logic       out_stall;
  logic [5:0] out_led_index;
  logic [7:0] out_green_out;
  logic [7:0] out_red_out;
  logic [7:0] out_blue_out;
  logic       out_frame_last;

  led_strip_effect_engine u_top (.*);

  typedef struct packed {
    logic [5:0]  idx;
    logic [23:0] grb;
    logic        last;
  } led_px_t;

  typedef struct {
    bit          is_cfg;
    logic [1:0]  reg_sel;
    logic [7:0]  reg_val;
    logic [1:0]  cmd;
    logic [7:0]  fan;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    bit          typed;
    logic [23:0] grb;
  } dir_row_t;

  led_px_t     px_q[$];
  logic [7:0]  sine_tab[ROM_LEN];
  logic [23:0] store_grb[LEDS];
  int unsigned tick_cnt, rb_frame, br_pos, br_level, br_base;
  bit          br_down;
  logic [1:0]  mode_r;
  logic [7:0]  speed_r, step_r;
  int          errors, reqs_sent, px_seen, frames_seen, wdog;
  int          idle_in, idle_out;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] sine_calc(int i);
    longint unsigned x, x2, t, s, a;
    bit neg;
    x = ((longint'(i) << 30) / 10) % Q_TWO_PI;
    neg = x > Q_PI;
    if (neg) x = x - Q_PI;
    if (x > Q_HALF_PI) x = Q_PI - x;
    x2 = (x * x) >> 30;
    t = x;
    s = x;
    for (int k = 1; k <= 12; k++) begin
      t = ((t * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      s = (k % 2 == 1) ? s - t : s + t;
    end
    a = 127 * s;
    return neg ? 8'(128 - ((a + (64'd1 << 30) - 1) >> 30)) : 8'(128 + (a >> 30));
  endfunction

  function automatic logic [23:0] hue_grb(int unsigned ph);
    if (ph >= PHASE_WRAP) ph = 0;
    return {sine_tab[ph + 20], sine_tab[ph], sine_tab[ph + 40]};
  endfunction

  function automatic int unsigned period_ticks();
    int unsigned sp;
    sp = speed_r < 1 ? 1 : (speed_r > 100 ? 100 : speed_r);
    return 100 - (sp - 1) * 90 / 99;
  endfunction

  task automatic next_base(int unsigned st);
    br_pos = br_pos + st;
    if (br_pos > 255) br_pos = 0;
    br_base = hue_grb(br_pos * st);
    br_level = 0;
    br_down = 0;
  endtask

  task automatic step_breath();
    int unsigned st;
    logic [23:0] c;
    st = step_r == 0 ? 1 : step_r;
    c = {8'((br_base[23:16] * br_level) >> 8), 8'((br_base[15:8] * br_level) >> 8),
         8'((br_base[7:0] * br_level) >> 8)};
    foreach (store_grb[k]) store_grb[k] = c;
    if (!br_down) begin
      br_level = br_level + st;
      if (br_level > 255) begin
        if (st <= 254) begin
          br_down = 1;
          br_level = 254 - st;
        end else next_base(st);
      end
    end else if (br_level >= st) br_level = br_level - st;
    else next_base(st);
  endtask

  task automatic queue_frame(bit typed, logic [23:0] grb);
    for (int k = 0; k < LEDS; k++)
      px_q.push_back('{idx: 6'(k), grb: typed ? grb : store_grb[k], last: k == LEDS - 1});
  endtask

  task automatic predict_frame(logic [1:0] cmd, logic [7:0] fan, logic [23:0] c,
                               bit typed, logic [23:0] tgrb);
    int unsigned st;
    case (cmd)
      CMD_TICK: begin
        if (mode_r == MODE_RAIN || mode_r == MODE_BREATH) begin
          if (tick_cnt == 0) begin
            if (mode_r == MODE_RAIN) begin
              st = (step_r == 0 || step_r > 10) ? 1 : step_r;
              foreach (store_grb[k]) store_grb[k] = hue_grb(rb_frame + k * st);
              rb_frame = (rb_frame + 1) & 8'hFF;
            end else step_breath();
            queue_frame(typed, tgrb);
          end
          tick_cnt++;
          if (tick_cnt >= period_ticks()) tick_cnt = 0;
        end
      end
      CMD_SET: begin
        if (fan >= 1 && fan <= FAN_NUM_DEF) begin
          for (int k = (fan - 1) * LEDS_PER_FAN_DEF; k < fan * LEDS_PER_FAN_DEF; k++)
            if (k < LEDS) store_grb[k] = c;
          queue_frame(typed, tgrb);
        end
      end
      CMD_OFF: begin
        foreach (store_grb[k]) store_grb[k] = '0;
        queue_frame(typed, tgrb);
      end
      default: ;
    endcase
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(logic [1:0] sel, logic [7:0] val);
    in_valid <= 1'b0;
    while (px_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= sel;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (sel)
      REG_MODE: begin
        mode_r = val[1:0];
        tick_cnt = 0;
        rb_frame = 0;
        br_pos = 0;
        br_level = 0;
        br_down = 0;
        br_base = hue_grb(0);
      end
      REG_SPEED: speed_r = val;
      REG_STEP: step_r = val;
      default: ;
    endcase
  endtask

  task automatic send_req(logic [1:0] cmd, logic [7:0] fan, logic [7:0] r, logic [7:0] g,
                          logic [7:0] b, bit typed, logic [23:0] tgrb);
    bit taken;
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_fan_id   <= fan;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) predict_frame(cmd, fan, {g, r, b}, typed, tgrb);
      @(posedge clk);
    end
    reqs_sent++;
  endtask

  always @(posedge clk) out_stall <= rst_n && ($urandom_range(99) < idle_out);

  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      px_seen++;
      if (px_q.size() == 0) report("unexpected led", out_led_index, -1);
      else begin
        led_px_t e;
        e = px_q.pop_front();
        if (out_led_index != e.idx) report("led_index", out_led_index, e.idx);
        if (out_green_out != e.grb[23:16]) report("green", out_green_out, e.grb[23:16]);
        if (out_red_out != e.grb[15:8]) report("red", out_red_out, e.grb[15:8]);
        if (out_blue_out != e.grb[7:0]) report("blue", out_blue_out, e.grb[7:0]);
        if (out_frame_last != e.last) report("frame_last", out_frame_last, e.last);
        if (e.last) frames_seen++;
      end
    end
  end

  always @(negedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) wdog = 0;
    else wdog++;
    if (wdog >= WDOG_LIMIT) begin
      $display("watchdog expired, %0d leds still expected", px_q.size());
      $display("tb_led_strip_effect_engine failed");
      $finish;
    end
  end

  dir_row_t dir_tab[22] = '{
    '{0, REG_MODE, 0, CMD_OFF,  8'd1,   0,    0,    0,    1, 24'h000000},
    '{0, REG_MODE, 0, CMD_SET,  8'd1,   8'hA5, 8'h5A, 8'hFF, 0, 0},
    '{0, REG_MODE, 0, CMD_SET,  8'd2,   8'hA5, 8'h5A, 8'hFF, 0, 0},
    '{0, REG_MODE, 0, CMD_SET,  8'd3,   8'hA5, 8'h5A, 8'hFF, 1, 24'h5AA5FF},
    '{0, REG_MODE, 0, CMD_SET,  8'd0,   8'hFF, 8'hFF, 8'hFF, 0, 0},
    '{0, REG_MODE, 0, CMD_SET,  8'd4,   8'hFF, 8'hFF, 8'hFF, 0, 0},
    '{0, REG_MODE, 0, CMD_SET,  8'd255, 8'h00, 8'h00, 8'h00, 0, 0},
    '{0, REG_MODE, 0, CMD_SPARE, 8'd1,  8'h12, 8'h34, 8'h56, 0, 0},
    '{0, REG_MODE, 0, CMD_TICK, 8'd0,   0,    0,    0,    0, 0},
    '{1, REG_MODE, MODE_SPARE, CMD_TICK, 0, 0, 0, 0, 0, 0},
    '{0, REG_MODE, 0, CMD_TICK, 8'd0,   0,    0,    0,    0, 0},
    '{1, REG_SPEED, 8'd255, CMD_TICK, 0, 0, 0, 0, 0, 0},
    '{1, REG_STEP, 8'd11, CMD_TICK, 0, 0, 0, 0, 0, 0},
    '{1, REG_MODE, MODE_RAIN, CMD_TICK, 0, 0, 0, 0, 0, 0},
    '{0, REG_MODE, 0, CMD_TICK, 8'd0,   0,    0,    0,    0, 0},
    '{0, REG_MODE, 0, CMD_TICK, 8'd0,   0,    0,    0,    0, 0},
    '{0, REG_MODE, 0, CMD_SET,  8'd2,   8'h01, 8'h80, 8'hFE, 0, 0},
    '{1, REG_STEP, 8'd255, CMD_TICK, 0, 0, 0, 0, 0, 0},
    '{1, REG_MODE, MODE_BREATH, CMD_TICK, 0, 0, 0, 0, 0, 0},
    '{0, REG_MODE, 0, CMD_TICK, 8'd0,   0,    0,    0,    0, 0},
    '{1, REG_SPEED, 8'd0, CMD_TICK, 0, 0, 0, 0, 0, 0},
    '{0, REG_MODE, 0, CMD_OFF,  8'd0,   0,    0,    0,    1, 24'h000000}
  };

  initial begin
    logic [7:0] speeds[6] = '{8'd0, 8'd1, 8'd100, 8'd255, 8'd99, 8'd98};
    logic [7:0] steps[7]  = '{8'd0, 8'd1, 8'd10, 8'd11, 8'd255, 8'd128, 8'd3};
    int roll;
    logic [7:0] fan;
    errors = 0;
    reqs_sent = 0;
    px_seen = 0;
    frames_seen = 0;
    wdog = 0;
    idle_in = 17;
    idle_out = 56;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = REG_MODE;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = CMD_TICK;
    in_fan_id = '0;
    in_red_in = '0;
    in_green_in = '0;
    in_blue_in = '0;
    out_stall = 1'b0;
    for (int i = 0; i < ROM_LEN; i++) sine_tab[i] = sine_calc(i);
    foreach (store_grb[k]) store_grb[k] = '0;
    tick_cnt = 0;
    rb_frame = 0;
    br_pos = 0;
    br_level = 0;
    br_down = 0;
    br_base = 0;
    mode_r = MODE_STATIC;
    speed_r = 8'd50;
    step_r = 8'd1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_reg(dir_tab[i].reg_sel, dir_tab[i].reg_val);
      else send_req(dir_tab[i].cmd, dir_tab[i].fan, dir_tab[i].red, dir_tab[i].green,
                    dir_tab[i].blue, dir_tab[i].typed, dir_tab[i].grb);
    end

    for (int seg = 0; seg < 12; seg++) begin
      if (seg == 4) begin
        idle_in = 56;
        idle_out = 17;
      end else if (seg == 8) begin
        idle_in = 0;
        idle_out = 0;
      end
      write_reg(REG_SPEED, $urandom_range(1) ? speeds[$urandom_range(5)] : 8'($urandom));
      write_reg(REG_STEP, $urandom_range(1) ? steps[$urandom_range(6)] : 8'($urandom));
      write_reg(REG_MODE, (seg % 4 == 3) ? 2'($urandom) : 2'(seg % 3));
      for (int n = 0; n < 22; n++) begin
        roll = $urandom_range(99);
        fan = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(FAN_NUM_DEF, 1));
        if (roll < 60) send_req(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 0, 0);
        else if (roll < 85) send_req(CMD_SET, fan, 8'($urandom), 8'($urandom),
                                     8'($urandom), 0, 0);
        else if (roll < 95) send_req(CMD_OFF, 8'($urandom), 8'($urandom), 8'($urandom),
                                     8'($urandom), 0, 0);
        else send_req(CMD_SPARE, fan, 8'($urandom), 8'($urandom), 8'($urandom), 0, 0);
      end
    end
    in_valid <= 1'b0;

    while (px_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d requests in static, rainbow and breathing modes", reqs_sent);
    $display("checked %0d leds in %0d frames under random stalls", px_seen, frames_seen);
    if (errors == 0) $display("tb_led_strip_effect_engine passed");
    else $display("tb_led_strip_effect_engine failed");
    $finish;
  end

endmodule
